// ===== hdl/ffba_pkg.sv =====
package ffba_pkg;

   // field widths
   localparam int BS_W    = 13;
   localparam int REQ_W   = 19;
   localparam int OFF_W   = 18;
   localparam int AVAIL_W = 19;

   // block size register
   localparam int BS_RESET = 16;
   localparam int BS_MAX   = 4096;

   // saturation of the available byte count
   localparam int AVAIL_MAX = 524287;

   // pool geometry default
   localparam int NUM_BLOCKS_DEF = 64;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_SIZE   = 2'd1,
      STAT_NO_SPACE   = 2'd2,
      STAT_BAD_OFFSET = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_SCAN,
      S_RL_READ,
      S_RL_WAIT,
      S_MARK,
      S_RESULT
   } state_type;

   // divider result bundle
   typedef struct packed {
      logic             done;
      logic [REQ_W-1:0] quot;
      logic [BS_W-1:0]  rem;
   } div_result_type;

endpackage

// ===== hdl/ffba_div.sv =====
module ffba_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ffba_pkg::REQ_W-1:0]       dividend,
   input  logic [ffba_pkg::BS_W-1:0]        divisor,
   output ffba_pkg::div_result_type         result
);
   import ffba_pkg::*;

   localparam int STEP_W = $clog2(REQ_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BS_W:0]     acc_ff, acc_in;
   logic [REQ_W-1:0]  qr_ff, qr_in;
   logic [BS_W-1:0]   dsr_ff, dsr_in;
   logic [BS_W:0]     shifted;
   logic [BS_W+1:0]   trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {acc_ff[BS_W-1:0], qr_ff[REQ_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      qr_in   = qr_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = '0;
         qr_in   = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[BS_W+1]) begin
            acc_in = trial[BS_W:0];
            qr_in  = {qr_ff[REQ_W-2:0], 1'b1};
         end else begin
            acc_in = shifted;
            qr_in  = {qr_ff[REQ_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(REQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      acc_ff  <= acc_in;
      qr_ff   <= qr_in;
      dsr_ff  <= dsr_in;
   end

   assign result.done = done_ff;
   assign result.quot = qr_ff;
   assign result.rem  = acc_ff[BS_W-1:0];

endmodule

// ===== hdl/ffba_ram.sv =====
module ffba_ram #(
   parameter int DEPTH = ffba_pkg::NUM_BLOCKS_DEF,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/first_fit_block_allocator.sv =====
// Allocate checks the size, divides the bytes by the block size, then scans the block
//   map one entry per cycle for the first free run and marks it; free divides the
//   offset, clears the run. One item is in work at a time; a waiting result does not block
//   acceptance of the next item. Reset (synchronous) runs a clearing pass of NUM_BLOCKS
//   cycles over both memories before the first item is accepted; block size resets to 16.
module first_fit_block_allocator #(
   parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [ffba_pkg::REQ_W-1:0]   req_request_bytes,
   input  logic [ffba_pkg::OFF_W-1:0]   req_free_offset,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ffba_pkg::status_type         rsp_status,
   output logic [ffba_pkg::OFF_W-1:0]   rsp_block_offset,
   output logic [ffba_pkg::AVAIL_W-1:0] rsp_available_bytes,
   input  logic                         csr_wr_en,
   input  logic [ffba_pkg::BS_W-1:0]    csr_wr_data
);
   import ffba_pkg::*;

   localparam int IW    = $clog2(NUM_BLOCKS);
   localparam int LW    = $clog2(NUM_BLOCKS + 1);
   localparam int PW    = BS_W + LW;
   localparam int CMPW  = (PW > REQ_W) ? PW : REQ_W;
   localparam int OMW   = IW + BS_W;
   localparam int AMW   = LW + BS_W;
   localparam int AMX   = (AMW > AVAIL_W) ? AMW : AVAIL_W;

   state_type         state_ff, state_in;
   logic [BS_W-1:0]   bs_ff, bs_in;
   op_type            op_ff, op_in;
   logic [REQ_W-1:0]  req_ff, req_in;
   logic [OFF_W-1:0]  foff_ff, foff_in;
   status_type        status_ff, status_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [LW-1:0]     run_ff, run_in;
   logic [LW-1:0]     scan_ff, scan_in;
   logic              rvalid_ff, rvalid_in;
   logic [IW-1:0]     rdidx_ff, rdidx_in;
   logic [IW-1:0]     mark_addr_ff, mark_addr_in;
   logic [LW-1:0]     mark_cnt_ff, mark_cnt_in;
   logic              mark_val_ff, mark_val_in;
   logic [LW-1:0]     biu_ff, biu_in;
   logic [IW-1:0]     clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]  rsp_off_ff, rsp_off_in;
   logic [AVAIL_W-1:0] rsp_avail_ff, rsp_avail_in;

   div_result_type    div_res;
   logic              div_start;
   logic [REQ_W-1:0]  div_dividend;

   logic              um_wr_en, um_wr_data, um_rd_en, um_rd_data;
   logic [IW-1:0]     um_wr_addr, um_rd_addr;
   logic              rl_wr_en, rl_rd_en;
   logic [IW-1:0]     rl_wr_addr, rl_rd_addr;
   logic [LW-1:0]     rl_wr_data, rl_rd_data;

   logic [CMPW-1:0]   pool;
   logic              bad_size;
   logic              free_bad;
   logic [LW-1:0]     alloc_len;
   logic              scan_issue;
   logic              scan_hit;
   logic              scan_end;
   logic [LW-1:0]     rl_max;
   logic [LW-1:0]     rl_len;
   logic              load_rsp;
   logic [OMW-1:0]    off_prod;
   logic [AMW-1:0]    avail_prod;
   logic [LW-1:0]     free_blocks;

   // divider for byte-to-block conversion
   ffba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (bs_ff),
      .result   (div_res)
   );

   // block usage map
   ffba_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(1)) u_used_map (
      .clock   (clock),
      .wr_en   (um_wr_en),
      .wr_addr (um_wr_addr),
      .wr_data (um_wr_data),
      .rd_en   (um_rd_en),
      .rd_addr (um_rd_addr),
      .rd_data (um_rd_data)
   );

   // run length per run head
   ffba_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(LW)) u_run_lengths (
      .clock   (clock),
      .wr_en   (rl_wr_en),
      .wr_addr (rl_wr_addr),
      .wr_data (rl_wr_data),
      .rd_en   (rl_rd_en),
      .rd_addr (rl_rd_addr),
      .rd_data (rl_rd_data)
   );

   // shared conditions
   always_comb begin
      pool       = CMPW'(bs_ff) * CMPW'(NUM_BLOCKS);
      bad_size   = (req_ff == '0) || (CMPW'(req_ff) > pool);
      free_bad   = (div_res.rem != '0) || (div_res.quot >= REQ_W'(NUM_BLOCKS));
      alloc_len  = LW'(div_res.quot) + LW'(div_res.rem != '0);
      scan_issue = (state_ff == S_SCAN) && (scan_ff < LW'(NUM_BLOCKS));
      scan_hit   = (state_ff == S_SCAN) && rvalid_ff && !um_rd_data
                   && ((run_ff + LW'(1)) == len_ff);
      scan_end   = (state_ff == S_SCAN) && rvalid_ff && !scan_hit
                   && (rdidx_ff == IW'(NUM_BLOCKS - 1));
      rl_max     = LW'(NUM_BLOCKS) - LW'(head_ff);
      rl_len     = (rl_rd_data > rl_max) ? rl_max : rl_rd_data;
      load_rsp   = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == IW'(NUM_BLOCKS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (op_ff == OP_ALLOC && bad_size) state_in = S_RESULT;
            else state_in = S_DIV;
         end
         S_DIV: begin
            if (div_res.done) begin
               if (op_ff == OP_ALLOC) state_in = S_SCAN;
               else if (free_bad) state_in = S_RESULT;
               else state_in = S_RL_READ;
            end
         end
         S_SCAN: begin
            if (scan_hit) state_in = S_MARK;
            else if (scan_end) state_in = S_RESULT;
         end
         S_RL_READ: state_in = S_RL_WAIT;
         S_RL_WAIT: begin
            if (rl_len == '0) state_in = S_RESULT;
            else state_in = S_MARK;
         end
         S_MARK: begin
            if (mark_cnt_ff == LW'(1)) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // state outputs: handshake, divider launch, memory ports
   always_comb begin
      req_ready    = (state_ff == S_IDLE);
      div_start    = (state_ff == S_CHECK) && !(op_ff == OP_ALLOC && bad_size);
      div_dividend = (op_ff == OP_ALLOC) ? req_ff : REQ_W'(foff_ff);
      um_rd_en     = scan_issue;
      um_rd_addr   = scan_ff[IW-1:0];
      rl_rd_en     = (state_ff == S_RL_READ);
      rl_rd_addr   = head_ff;
      um_wr_en     = 1'b0;
      um_wr_addr   = mark_addr_ff;
      um_wr_data   = mark_val_ff;
      rl_wr_en     = 1'b0;
      rl_wr_addr   = head_ff;
      rl_wr_data   = mark_val_ff ? len_ff : '0;
      case (state_ff)
         S_CLEAR: begin
            um_wr_en   = 1'b1;
            um_wr_addr = clr_ff;
            um_wr_data = 1'b0;
            rl_wr_en   = 1'b1;
            rl_wr_addr = clr_ff;
            rl_wr_data = '0;
         end
         S_MARK: begin
            um_wr_en = 1'b1;
            rl_wr_en = 1'b1;
         end
         default: begin
            um_wr_en = 1'b0;
            rl_wr_en = 1'b0;
         end
      endcase
   end

   // result products
   always_comb begin
      free_blocks = LW'(NUM_BLOCKS) - biu_ff;
      off_prod    = OMW'(head_ff) * OMW'(bs_ff);
      avail_prod  = AMW'(free_blocks) * AMW'(bs_ff);
   end

   // datapath next values
   always_comb begin
      bs_in         = bs_ff;
      op_in         = op_ff;
      req_in        = req_ff;
      foff_in       = foff_ff;
      status_in     = status_ff;
      len_in        = len_ff;
      head_in       = head_ff;
      run_in        = run_ff;
      scan_in       = scan_ff;
      rvalid_in     = scan_issue;
      rdidx_in      = scan_ff[IW-1:0];
      mark_addr_in  = mark_addr_ff;
      mark_cnt_in   = mark_cnt_ff;
      mark_val_in   = mark_val_ff;
      biu_in        = biu_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_avail_in  = rsp_avail_ff;

      // clamp block size writes into 1..4096
      if (csr_wr_en) begin
         if (csr_wr_data == '0) bs_in = BS_W'(1);
         else if (csr_wr_data > BS_W'(BS_MAX)) bs_in = BS_W'(BS_MAX);
         else bs_in = csr_wr_data;
      end

      if (state_ff == S_CLEAR) clr_in = clr_ff + IW'(1);

      // capture the item
      if (req_valid && req_ready) begin
         op_in   = op_type'(req_opcode);
         req_in  = req_request_bytes;
         foff_in = req_free_offset;
      end

      if (state_ff == S_CHECK) begin
         if (op_ff == OP_ALLOC && bad_size) status_in = STAT_BAD_SIZE;
         else status_in = STAT_OK;
      end

      // divider done: set run length or head block
      if (state_ff == S_DIV && div_res.done) begin
         len_in  = alloc_len;
         head_in = div_res.quot[IW-1:0];
         run_in  = '0;
         scan_in = '0;
         if (op_ff == OP_FREE && free_bad) status_in = STAT_BAD_OFFSET;
      end

      // first-fit scan: count consecutive free blocks
      if (scan_issue) scan_in = scan_ff + LW'(1);
      if (state_ff == S_SCAN && rvalid_ff) begin
         run_in = um_rd_data ? '0 : run_ff + LW'(1);
      end
      if (scan_hit) begin
         head_in      = rdidx_ff - IW'(len_ff) + IW'(1);
         mark_addr_in = rdidx_ff - IW'(len_ff) + IW'(1);
         mark_cnt_in  = len_ff;
         mark_val_in  = 1'b1;
         biu_in       = biu_ff + len_ff;
      end
      if (scan_end) status_in = STAT_NO_SPACE;

      // release path
      if (state_ff == S_RL_WAIT) begin
         len_in       = rl_len;
         mark_addr_in = head_ff;
         mark_cnt_in  = rl_len;
         mark_val_in  = 1'b0;
         biu_in       = (biu_ff >= rl_len) ? biu_ff - rl_len : '0;
      end

      // walk the run
      if (state_ff == S_MARK) begin
         mark_addr_in = mark_addr_ff + IW'(1);
         mark_cnt_in  = mark_cnt_ff - LW'(1);
      end

      // load the result register
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         if (op_ff == OP_ALLOC && status_ff == STAT_OK) rsp_off_in = OFF_W'(off_prod);
         else rsp_off_in = '0;
         if (AMX'(avail_prod) > AMX'(AVAIL_MAX)) rsp_avail_in = AVAIL_W'(AVAIL_MAX);
         else rsp_avail_in = AVAIL_W'(avail_prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         bs_ff        <= BS_W'(BS_RESET);
         biu_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bs_ff        <= bs_in;
         biu_ff       <= biu_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      req_ff        <= req_in;
      foff_ff       <= foff_in;
      status_ff     <= status_in;
      len_ff        <= len_in;
      head_ff       <= head_in;
      run_ff        <= run_in;
      scan_ff       <= scan_in;
      rdidx_ff      <= rdidx_in;
      mark_addr_ff  <= mark_addr_in;
      mark_cnt_ff   <= mark_cnt_in;
      mark_val_ff   <= mark_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_avail_ff  <= rsp_avail_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_block_offset    = rsp_off_ff;
   assign rsp_available_bytes = rsp_avail_ff;

endmodule

// ===== hdl/ffba_checker.sv =====
module ffba_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input ffba_pkg::status_type         rsp_status,
   input logic [ffba_pkg::OFF_W-1:0]   rsp_block_offset,
   input logic [ffba_pkg::AVAIL_W-1:0] rsp_available_bytes
);
   import ffba_pkg::*;

   // reset starts the clearing pass: no result, no item taken
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("result or ready right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_block_offset) && $stable(rsp_available_bytes))
      else $error("stalled result changed");

   // failed results carry no offset
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_block_offset == '0)
      else $error("offset on a failed result");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

// ===== sim/pool_alloc_checker.sv =====
`timescale 1ns / 1ps

module pool_alloc_checker #(
   parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [ffba_pkg::REQ_W-1:0]   req_request_bytes,
   input  logic [ffba_pkg::OFF_W-1:0]   req_free_offset,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  ffba_pkg::status_type         rsp_status,
   input  logic [ffba_pkg::OFF_W-1:0]   rsp_block_offset,
   input  logic [ffba_pkg::AVAIL_W-1:0] rsp_available_bytes,
   input  logic                         csr_wr_en,
   input  logic [ffba_pkg::BS_W-1:0]    csr_wr_data,
   output int                           mismatches,
   output int                           pending
);

   import ffba_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [OFF_W-1:0]   offset;
      logic [AVAIL_W-1:0] avail;
   } pool_result_type;

   // shadow copy of the pool
   bit              block_taken [NUM_BLOCKS];
   int              run_span [NUM_BLOCKS];
   int              blocks_held;
   int              block_bytes;
   pool_result_type due_results [$];
   int              result_seq;

   initial begin
      mismatches = 0;
      pending    = 0;
      result_seq = 0;
   end

   // print one line per mismatch and count it
   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t: result %0d, %s: expected %0d, got %0d",
               $time, result_seq, what, want, got);
      mismatches++;
   endtask

   // apply one accepted item to the shadow pool and queue its result
   task automatic predict_pool_step(input logic opcode, input int req_bytes,
                                    input int free_at);
      pool_result_type r;
      int              span;
      int              start;
      int              idx;
      int              k;
      int              avail;
      bit              found;
      r.status = STAT_OK;
      r.offset = '0;
      if (op_type'(opcode) == OP_ALLOC) begin
         if (req_bytes == 0 || req_bytes > block_bytes * NUM_BLOCKS) begin
            r.status = STAT_BAD_SIZE;
         end else begin
            // first fit: lowest start whose whole run is free
            span  = (req_bytes + block_bytes - 1) / block_bytes;
            start = 0;
            found = 1'b0;
            while (!found && start + span <= NUM_BLOCKS) begin
               found = 1'b1;
               for (k = 0; k < span; k++)
                  if (block_taken[start + k])
                     found = 1'b0;
               if (!found)
                  start++;
            end
            if (!found) begin
               r.status = STAT_NO_SPACE;
            end else begin
               for (k = 0; k < span; k++)
                  block_taken[start + k] = 1'b1;
               run_span[start] = span;
               blocks_held += span;
               r.offset = OFF_W'(start * block_bytes);
            end
         end
      end else begin
         idx = free_at / block_bytes;
         if (free_at % block_bytes != 0 || idx >= NUM_BLOCKS) begin
            r.status = STAT_BAD_OFFSET;
         end else begin
            // release the run headed here; a non-head releases nothing
            span = run_span[idx];
            if (span > NUM_BLOCKS - idx)
               span = NUM_BLOCKS - idx;
            for (k = 0; k < span; k++)
               block_taken[idx + k] = 1'b0;
            blocks_held = (blocks_held >= span) ? blocks_held - span : 0;
            run_span[idx] = 0;
         end
      end
      avail = (blocks_held < NUM_BLOCKS) ? (NUM_BLOCKS - blocks_held) * block_bytes : 0;
      if (avail > AVAIL_MAX)
         avail = AVAIL_MAX;
      r.avail = AVAIL_W'(avail);
      due_results.push_back(r);
   endtask

   // compare an accepted result with the oldest expectation
   task automatic check_result();
      pool_result_type want;
      if (due_results.size() == 0) begin
         report_mismatch("unexpected result, status", -1, int'(rsp_status));
      end else begin
         want = due_results.pop_front();
         if (rsp_status !== want.status)
            report_mismatch("status", int'(want.status), int'(rsp_status));
         if (rsp_block_offset !== want.offset)
            report_mismatch("block_offset", int'(want.offset), int'(rsp_block_offset));
         if (rsp_available_bytes !== want.avail)
            report_mismatch("available_bytes", int'(want.avail),
                            int'(rsp_available_bytes));
      end
      result_seq++;
   endtask

   // watch the channels and the register port at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         block_bytes = BS_RESET;
         blocks_held = 0;
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            block_taken[i] = 1'b0;
            run_span[i]    = 0;
         end
         due_results.delete();
      end else begin
         if (csr_wr_en) begin
            block_bytes = int'(csr_wr_data);
            if (block_bytes == 0)
               block_bytes = 1;
            if (block_bytes > BS_MAX)
               block_bytes = BS_MAX;
         end
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready)
            predict_pool_step(req_opcode, int'(req_request_bytes), int'(req_free_offset));
      end
      pending <= due_results.size();
   end

endmodule

// ===== sim/tb_first_fit_block_allocator.sv =====
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;

   import ffba_pkg::*;

   localparam int POOL_BLOCKS  = NUM_BLOCKS_DEF;
   localparam int LIMIT_CYCLES = 1500000;
   localparam int OFF_TOP      = 262143;
   localparam int REQ_TOP      = 262144;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_opcode;
   logic [REQ_W-1:0]   req_request_bytes;
   logic [OFF_W-1:0]   req_free_offset;
   logic               rsp_valid;
   logic               rsp_ready;
   status_type         rsp_status;
   logic [OFF_W-1:0]   rsp_block_offset;
   logic [AVAIL_W-1:0] rsp_available_bytes;
   logic               csr_wr_en;
   logic [BS_W-1:0]    csr_wr_data;

   int mismatches;
   int pending;
   int cycles;
   int pool_unit;
   bit steady_flow;
   int bs_plan [9] = '{1, 4096, 0, 8191, 5000, 7, 16, 100, -1};

   first_fit_block_allocator #(
      .NUM_BLOCKS(POOL_BLOCKS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_request_bytes  (req_request_bytes),
      .req_free_offset    (req_free_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_block_offset   (rsp_block_offset),
      .rsp_available_bytes(rsp_available_bytes),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   pool_alloc_checker #(
      .NUM_BLOCKS(POOL_BLOCKS)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_request_bytes  (req_request_bytes),
      .req_free_offset    (req_free_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_block_offset   (rsp_block_offset),
      .rsp_available_bytes(rsp_available_bytes),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // stop a hung run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // idle length: mostly none or short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // stall the result side at random unless the flow is steady
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (steady_flow) begin
            rsp_ready = 1'b1;
         end else begin
            stall = idle_len();
            if (stall == 0) begin
               rsp_ready = 1'b1;
            end else begin
               rsp_ready = 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // present one item after an optional gap and hold it until accepted
   task automatic send_item(input op_type op, input int bytes, input int at);
      int gap;
      gap = steady_flow ? 0 : idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         = 1'b1;
      req_opcode        = op;
      req_request_bytes = REQ_W'(bytes);
      req_free_offset   = OFF_W'(at);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic alloc_item(input int bytes);
      send_item(OP_ALLOC, bytes, $urandom_range(0, OFF_TOP));
   endtask

   task automatic free_item(input int at);
      send_item(OP_FREE, $urandom_range(0, REQ_TOP), at);
   endtask

   // drop valid and hold until every expected result is in
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // write the block size once the allocator is idle
   task automatic set_block_size(input int value);
      drain();
      csr_wr_data = BS_W'(value);
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      pool_unit   = value & 13'h1FFF;
      if (pool_unit == 0)
         pool_unit = 1;
      if (pool_unit > BS_MAX)
         pool_unit = BS_MAX;
   endtask

   // request sizes: mostly small legal runs, some edge and noise sizes
   function automatic int rand_request();
      int r;
      int pool;
      r    = $urandom_range(0, 99);
      pool = pool_unit * POOL_BLOCKS;
      if (r < 70)
         return $urandom_range(1, pool_unit * $urandom_range(1, 8));
      if (r < 80)
         return $urandom_range(1, pool);
      if (r < 85)
         return 0;
      if (r < 90)
         return (pool >= REQ_TOP) ? REQ_TOP : pool + $urandom_range(1, REQ_TOP - pool);
      return $urandom_range(0, REQ_TOP);
   endfunction

   // free offsets: mostly block starts low in the pool, which hit run heads
   function automatic int rand_offset();
      int r;
      int pool;
      r    = $urandom_range(0, 99);
      pool = pool_unit * POOL_BLOCKS;
      if (r < 70)
         return pool_unit * $urandom_range(0, $urandom_range(0, POOL_BLOCKS - 1));
      if (r < 80)
         return $urandom_range((pool < OFF_TOP) ? pool : OFF_TOP, OFF_TOP);
      if (r < 90 && pool_unit > 1)
         return pool_unit * $urandom_range(0, POOL_BLOCKS - 1) +
                $urandom_range(1, pool_unit - 1);
      return $urandom_range(0, OFF_TOP);
   endfunction

   task automatic run_random(input int count);
      repeat (count) begin
         if ($urandom_range(0, 99) < 55)
            alloc_item(rand_request());
         else
            free_item(rand_offset());
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_ALLOC;
      req_request_bytes = '0;
      req_free_offset   = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      steady_flow       = 1'b0;
      pool_unit         = BS_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // bad sizes: zero, one past the pool, 2^18
      alloc_item(0);
      alloc_item(1025);
      alloc_item(REQ_TOP);
      // small runs packed from block 0
      alloc_item(1);
      alloc_item(16);
      alloc_item(17);
      // misaligned, past the pool, largest offset
      free_item(8);
      free_item(1024);
      free_item(OFF_TOP);
      // free a run, then a start that heads no run, then a run interior
      free_item(16);
      free_item(16);
      free_item(48);
      // no run long enough, then fill the hole and the rest of the pool, then one more
      alloc_item(1000);
      alloc_item(16);
      alloc_item(960);
      alloc_item(1);
      // empty the pool, then claim it whole
      free_item(0);
      free_item(16);
      free_item(32);
      free_item(64);
      alloc_item(1024);
      alloc_item(1023);
      free_item(0);

      // block size phases, live runs kept across each change
      foreach (bs_plan[p]) begin
         set_block_size((bs_plan[p] < 0) ? $urandom_range(1, 8191) : bs_plan[p]);
         steady_flow = (p == 6);
         if (p == 2) begin
            run_random(30);
            drain();
            run_random(31);
         end else begin
            run_random(61);
         end
      end
      steady_flow = 1'b0;

      drain();
      repeat (200) @(negedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== first_fit_block_allocator.f =====
hdl/ffba_pkg.sv
hdl/ffba_div.sv
hdl/ffba_ram.sv
hdl/first_fit_block_allocator.sv
hdl/ffba_checker.sv
sim/pool_alloc_checker.sv
sim/tb_first_fit_block_allocator.sv
